// File: hdl/dnsf_pkg.sv
// Shared types and constants for the DNS response packet filter.
// No dependencies; imported by every module of the block.
package dnsf_pkg;

  localparam int unsigned MaskW      = 64;  // socket mask register width
  localparam int unsigned QueueW     = 6;   // receive queue index width
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 6;   // byte counter, saturates at CountMax
  localparam int unsigned QueueSlots = 64;  // default queue slot count

  localparam logic [CountW-1:0] CountMax = 6'd63;

  // Byte offsets within the Ethernet frame
  localparam logic [CountW-1:0] PosEthHi    = 6'd12;
  localparam logic [CountW-1:0] PosEthLo    = 6'd13;
  localparam logic [CountW-1:0] PosV4Ihl    = 6'd14;
  localparam logic [CountW-1:0] PosV4Proto  = 6'd23;
  localparam logic [CountW-1:0] PosV4PortHi = 6'd34;
  localparam logic [CountW-1:0] PosV4PortLo = 6'd35;
  localparam logic [CountW-1:0] PosV6Next   = 6'd20;
  localparam logic [CountW-1:0] PosV6PortHi = 6'd54;
  localparam logic [CountW-1:0] PosV6PortLo = 6'd55;
  // Last offset needed for a full UDP header (42 / 62 bytes)
  localparam logic [CountW-1:0] PosV4MinEnd = 6'd41;
  localparam logic [CountW-1:0] PosV6MinEnd = 6'd61;

  localparam logic [15:0]      EthTypeV4 = 16'h0800;
  localparam logic [15:0]      EthTypeV6 = 16'h86DD;
  localparam logic [ByteW-1:0] ProtoUdp  = 8'd17;
  localparam logic [3:0]       IhlNoOpts = 4'd5;
  localparam logic [ByteW-1:0] DnsPortHi = 8'd0;
  localparam logic [ByteW-1:0] DnsPortLo = 8'd53;

  typedef enum logic [1:0] {
    KindOther = 2'd0,
    KindV4    = 2'd1,
    KindV6    = 2'd2
  } net_kind_e;

  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic              last;
    logic [QueueW-1:0] queue;
  } item_t;

endpackage

// File: hdl/dnsf_in_stage.sv
// Input register stage of the DNS response packet filter.
// Depends on dnsf_pkg (item_t).
module dnsf_in_stage import dnsf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  out_free_i,   // result register can take a verdict this cycle
  output logic  fire_o,       // held item is consumed by the parser
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // A non-last byte never needs the result register
  assign fire_o     = valid_q & (~item_q.last | out_free_i);
  assign in_ready_o = ~valid_q | fire_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: hdl/dnsf_parser.sv
// Header parser: tracks byte offset and header checks for one frame.
// Depends on dnsf_pkg (offsets, constants, net_kind_e, item_t).
module dnsf_parser import dnsf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  output logic  match_o     // frame qualifies, valid with the last byte
);

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]  eth_hi_q, eth_hi_d;
  net_kind_e         kind_q, kind_d;
  logic              xport_ok_q, xport_ok_d;
  logic              ihl_ok_q, ihl_ok_d;
  logic              port_hi_q, port_hi_d;
  logic              port_ok_q, port_ok_d;

  logic [ByteW-1:0]  b;
  logic [CountW-1:0] pos;

  assign b   = item_i.data;
  assign pos = cnt_q;

  always_comb begin
    eth_hi_d   = eth_hi_q;
    kind_d     = kind_q;
    xport_ok_d = xport_ok_q;
    ihl_ok_d   = ihl_ok_q;
    port_hi_d  = port_hi_q;
    port_ok_d  = port_ok_q;
    cnt_d      = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;

    if (pos == PosEthHi) begin
      eth_hi_d = b;
    end
    if (pos == PosEthLo) begin
      if ({eth_hi_q, b} == EthTypeV4) begin
        kind_d = KindV4;
      end else if ({eth_hi_q, b} == EthTypeV6) begin
        kind_d = KindV6;
      end else begin
        kind_d = KindOther;
      end
    end

    // Kind is settled at offset 13, before any of these offsets
    case (kind_q)
      KindV4: begin
        if (pos == PosV4Ihl)    ihl_ok_d   = (b[3:0] == IhlNoOpts);
        if (pos == PosV4Proto)  xport_ok_d = (b == ProtoUdp);
        if (pos == PosV4PortHi) port_hi_d  = (b == DnsPortHi);
        if (pos == PosV4PortLo) port_ok_d  = port_hi_q & (b == DnsPortLo);
      end
      KindV6: begin
        if (pos == PosV6Next)   xport_ok_d = (b == ProtoUdp);
        if (pos == PosV6PortHi) port_hi_d  = (b == DnsPortHi);
        if (pos == PosV6PortLo) port_ok_d  = port_hi_q & (b == DnsPortLo);
      end
      default: ;
    endcase
  end

  always_comb begin
    case (kind_d)
      KindV4:  match_o = xport_ok_d & ihl_ok_d & port_ok_d & (pos >= PosV4MinEnd);
      KindV6:  match_o = xport_ok_d & port_ok_d & (pos >= PosV6MinEnd);
      default: match_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      eth_hi_q   <= '0;
      kind_q     <= KindOther;
      xport_ok_q <= 1'b0;
      ihl_ok_q   <= 1'b0;
      port_hi_q  <= 1'b0;
      port_ok_q  <= 1'b0;
    end else if (fire_i) begin
      if (item_i.last) begin
        cnt_q      <= '0;
        eth_hi_q   <= '0;
        kind_q     <= KindOther;
        xport_ok_q <= 1'b0;
        ihl_ok_q   <= 1'b0;
        port_hi_q  <= 1'b0;
        port_ok_q  <= 1'b0;
      end else begin
        cnt_q      <= cnt_d;
        eth_hi_q   <= eth_hi_d;
        kind_q     <= kind_d;
        xport_ok_q <= xport_ok_d;
        ihl_ok_q   <= ihl_ok_d;
        port_hi_q  <= port_hi_d;
        port_ok_q  <= port_ok_d;
      end
    end
  end

endmodule

// File: hdl/dns_response_packet_filter_top.sv
// Top level of the DNS response packet filter: socket mask register,
// result register. Depends on dnsf_pkg, dnsf_in_stage, dnsf_parser.
//
// Channel   Dir  Payload                                   Transfers
// s_axis    in   tdata=packet_byte, tlast=last_byte,        one per frame byte
//                tuser=queue_index
// m_axis    out  tdata={pad, target_queue, verdict}         one per frame (last byte)
// cfg       in   cfg_wdata_i = socket_present_mask          on cfg_we_i
//
// Throughput is one byte per cycle unless m_axis stalls. The verdict is valid
// on m_axis once the last byte of a frame has left the input register and the
// result register has loaded the verdict for that frame. Reset clears
// the frame state, the socket mask and both valid flags. A stalled m_axis only
// holds back the last byte of the next frame; earlier bytes keep flowing
// through the parser.
module dns_response_packet_filter_top import dnsf_pkg::*; #(
  parameter int unsigned QUEUE_SLOTS = QueueSlots  // 1..64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] packet_byte
  input  logic             s_axis_tlast,   // last_byte
  input  logic [QueueW-1:0] s_axis_tuser,  // [5:0] queue_index
  // verdict stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] verdict, [6:1] target_queue, [7] zero
  // configuration
  input  logic             cfg_we_i,
  input  logic [MaskW-1:0] cfg_wdata_i     // socket_present_mask
);

  item_t             in_item, s1_item;
  logic              s1_fire, out_free, match;
  logic [QUEUE_SLOTS-1:0] mask_q;
  logic [MaskW-1:0]  mask_ext;
  logic              hit;

  logic              out_valid_q, out_valid_d;
  logic              verdict_q;
  logic [QueueW-1:0] target_q;

  assign in_item.data  = s_axis_tdata;
  assign in_item.last  = s_axis_tlast;
  assign in_item.queue = s_axis_tuser;

  assign out_free = ~out_valid_q | m_axis_tready;

  dnsf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .out_free_i (out_free),
    .fire_o     (s1_fire),
    .item_o     (s1_item)
  );

  dnsf_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (s1_fire),
    .item_i  (s1_item),
    .match_o (match)
  );

  // Queues at or above QUEUE_SLOTS read a zero bit of the extended mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i[QUEUE_SLOTS-1:0];
    end
  end

  assign mask_ext = MaskW'(mask_q);
  assign hit      = match & mask_ext[s1_item.queue];

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_item.last) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_item.last) begin
      verdict_q <= hit;
      target_q  <= hit ? s1_item.queue : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, target_q, verdict_q};

endmodule
